FILE: sv/sci_pkg.sv
`timescale 1ns / 1ps

package sci_pkg;

    localparam int COMP_N      = 6;
    localparam int COMP_W      = 32;
    localparam int TIME_W      = 40;
    localparam int NUM_W       = 16;
    localparam int DIFF_W      = COMP_W + 1;
    localparam int SEL_W       = 3;
    localparam int MODE_W      = 2;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = ((COMP_N * COMP_W + TIME_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((COMP_N * COMP_W + TIME_W + NUM_W + 7) / 8) * 8;

    localparam logic [NUM_W-1:0] NUM_MAX = '1;

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_SELECT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LEVEL  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MODE   = 2'd2;

    // crossing direction modes
    localparam logic [MODE_W-1:0] MODE_UP     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DOWN   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EITHER = 2'd2;

    localparam logic [SEL_W-1:0] SELECT_RESET = 3'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_MUL,
        ST_FINISH,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic alpha_bit;
        logic finish;
    } lane_ctrl_t;

endpackage

FILE: sv/sci_divider.sv
`timescale 1ns / 1ps

module sci_divider
    import sci_pkg::*;
#(
    parameter int FRAC_BITS = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [COMP_W-1:0]    num,
    input  logic [DIFF_W-1:0]    den,
    output logic                 done,
    output logic [FRAC_BITS-1:0] quotient
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic [DIFF_W-1:0]    rem_reg, rem_next;
    logic [DIFF_W-1:0]    den_reg, den_next;
    logic [FRAC_BITS-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [DIFF_W:0]      shifted;
    logic [DIFF_W:0]      trial;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        shifted   = {rem_reg, 1'b0};
        trial     = shifted - {1'b0, den_reg};
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = DIFF_W'(num);
            den_next = den;
            quo_next = '0;
            cnt_next = CNT_W'(FRAC_BITS);
        end
        else if (cnt_reg != '0)
        begin
            if (!trial[DIFF_W])
                rem_next = trial[DIFF_W-1:0];
            else
                rem_next = shifted[DIFF_W-1:0];
            quo_next  = {quo_reg[FRAC_BITS-2:0], ~trial[DIFF_W]};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: sv/sci_lane.sv
`timescale 1ns / 1ps

module sci_lane
    import sci_pkg::*;
#(
    parameter int W = 32
) (
    input  logic       clk,
    input  lane_ctrl_t ctrl,
    input  logic [W:0] a,
    input  logic [W:0] b,
    output logic [W-1:0] result
);

    logic [W-1:0] a_reg, a_next;
    logic [W:0]   d_reg, d_next;
    logic [W+1:0] acc_reg, acc_next;
    logic [W-1:0] res_reg, res_next;
    logic [W+1:0] sum;

    // shift-add multiply, multiplier bits LSB first; each step halves with
    // floor, so the result is floor(alpha * d / 2^FRAC_BITS)
    always_comb
    begin
        sum      = acc_reg + (ctrl.alpha_bit ? {d_reg[W], d_reg} : '0);
        a_next   = a_reg;
        d_next   = d_reg;
        acc_next = acc_reg;
        res_next = res_reg;
        if (ctrl.load)
        begin
            a_next   = a[W-1:0];
            d_next   = b - a;
            acc_next = '0;
        end
        else if (ctrl.step)
        begin
            acc_next = {sum[W+1], sum[W+1:1]};
        end
        if (ctrl.finish)
            res_next = a_reg + acc_reg[W-1:0];
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        d_reg   <= d_next;
        acc_reg <= acc_next;
        res_reg <= res_next;
    end

    assign result = res_reg;

endmodule

FILE: sv/section_crossing_interpolator.sv
`timescale 1ns / 1ps

// An item that causes no crossing leaves the block idle; the next is accepted right after.
// An item that crosses the section goes through setup, divide, multiply, finish and hold
// states before its result shows, paced by the serial divider and the shift-add lanes,
// one bit a cycle each; the next item is taken in the cycle the result appears.
// A stalled result holds in the output register and delays only the next crossing.
// rst_n is asynchronous, active low: it clears the history-valid flag, count and handshakes, loads defaults.
module section_crossing_interpolator
    import sci_pkg::*;
#(
    parameter int FRAC_BITS   = 24,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, sample_time
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // trajectory_start
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // cross_x, cross_y, cross_z, cross_vx, cross_vy, cross_vz, cross_time,
    // crossing_number
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int MCNT_W    = $clog2(FRAC_BITS + 1);
    localparam int CNT_EXT_W = (COUNT_WIDTH > NUM_W) ? COUNT_WIDTH : NUM_W;

    state_t state_reg, state_next;

    logic [SEL_W-1:0]       select_reg, select_next;
    logic [COMP_W-1:0]      level_reg, level_next;
    logic [MODE_W-1:0]      mode_reg, mode_next;
    logic                   have_prev_reg, have_prev_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [COMP_W-1:0]      prev_comp_reg [COMP_N];
    logic [TIME_W-1:0]      prev_time_reg;
    logic [DIFF_W-1:0]      dp_reg, dc_reg;
    logic [NUM_W-1:0]       num_reg, num_next;
    logic [FRAC_BITS-1:0]   alpha_reg, alpha_next;
    logic [MCNT_W-1:0]      mcnt_reg, mcnt_next;
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;

    logic [COMP_W-1:0]      cur_comp [COMP_N];
    logic [TIME_W-1:0]      cur_time;
    logic [COMP_W-1:0]      lane_res [COMP_N];
    logic [TIME_W-1:0]      time_res;

    logic                   accept;
    logic                   sel_ok;
    logic [COMP_W-1:0]      prev_sel, cur_sel;
    logic [DIFF_W-1:0]      dp, dc;
    logic                   dp_pos, dp_neg, dc_pos, dc_neg;
    logic                   up, down, mode_hit, hit;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [CNT_EXT_W-1:0]   count_ext;
    logic [DIFF_W-1:0]      np_abs, den;
    logic                   div_start, div_done;
    logic [FRAC_BITS-1:0]   quotient;
    logic                   out_free, out_load;
    lane_ctrl_t             lane_ctrl;

    // unpack the input transfer
    always_comb
    begin
        for (int i = 0; i < COMP_N; i++)
            cur_comp[i] = s_tdata[i*COMP_W +: COMP_W];
        cur_time = s_tdata[COMP_N*COMP_W +: TIME_W];
    end

    assign accept = s_tvalid && s_tready;

    // crossing detection on the selected component
    always_comb
    begin
        sel_ok   = (select_reg < SEL_W'(COMP_N));
        prev_sel = sel_ok ? prev_comp_reg[select_reg] : '0;
        cur_sel  = sel_ok ? cur_comp[select_reg] : '0;
        dp       = {prev_sel[COMP_W-1], prev_sel} - {level_reg[COMP_W-1], level_reg};
        dc       = {cur_sel[COMP_W-1], cur_sel} - {level_reg[COMP_W-1], level_reg};
        dp_neg   = dp[DIFF_W-1];
        dc_neg   = dc[DIFF_W-1];
        dp_pos   = !dp[DIFF_W-1] && (dp != '0);
        dc_pos   = !dc[DIFF_W-1] && (dc != '0);
        up       = dp_neg && dc_pos;
        down     = dp_pos && dc_neg;
        unique case (mode_reg)
            MODE_UP:     mode_hit = up;
            MODE_DOWN:   mode_hit = down;
            MODE_EITHER: mode_hit = up || down;
            default:     mode_hit = 1'b0;
        endcase
        hit = !s_tuser && have_prev_reg && sel_ok && mode_hit;
    end

    // crossing count, saturating; the reported number clamps to its field
    always_comb
    begin
        count_inc = (count_reg == '1) ? count_reg : count_reg + 1'b1;
        count_ext = CNT_EXT_W'(count_inc);
        num_next  = num_reg;
        if (accept && hit)
            num_next = (count_ext > CNT_EXT_W'(NUM_MAX)) ? NUM_MAX : count_ext[NUM_W-1:0];
        count_next = count_reg;
        if (accept)
        begin
            if (s_tuser)
                count_next = '0;
            else if (hit)
                count_next = count_inc;
        end
        have_prev_next = have_prev_reg || accept;
    end

    // operands of the divide: |dp| over |dp| + |dc|, the signs being opposite
    always_comb
    begin
        np_abs = dp_reg[DIFF_W-1] ? (DIFF_W'(0) - dp_reg) : dp_reg;
        den    = dp_reg[DIFF_W-1] ? (dc_reg - dp_reg) : (dp_reg - dc_reg);
    end

    // configuration writes
    always_comb
    begin
        select_next = select_reg;
        level_next  = level_reg;
        mode_next   = mode_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_SELECT: select_next = cfg_wdata[SEL_W-1:0];
                REG_LEVEL:  level_next  = cfg_wdata[COMP_W-1:0];
                REG_MODE:   mode_next   = cfg_wdata[MODE_W-1:0];
                default:    ;
            endcase
        end
    end

    assign out_free = !m_valid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept && hit)
                    state_next = ST_SETUP;
            ST_SETUP:
                state_next = ST_DIV;
            ST_DIV:
                if (div_done)
                    state_next = ST_MUL;
            ST_MUL:
                if (mcnt_reg == MCNT_W'(1))
                    state_next = ST_FINISH;
            ST_FINISH:
                state_next = ST_HOLD;
            ST_HOLD:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        s_tready            = 1'b0;
        div_start           = 1'b0;
        out_load            = 1'b0;
        lane_ctrl.load      = 1'b0;
        lane_ctrl.step      = 1'b0;
        lane_ctrl.finish    = 1'b0;
        lane_ctrl.alpha_bit = alpha_reg[0];
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready       = 1'b1;
                lane_ctrl.load = accept && hit;
            end
            ST_SETUP:  div_start        = 1'b1;
            ST_DIV:    ;
            ST_MUL:    lane_ctrl.step   = 1'b1;
            ST_FINISH: lane_ctrl.finish = 1'b1;
            ST_HOLD:   out_load         = out_free;
            default:   ;
        endcase
    end

    // multiplier bit sequencing
    always_comb
    begin
        alpha_next = alpha_reg;
        mcnt_next  = mcnt_reg;
        if ((state_reg == ST_DIV) && div_done)
        begin
            alpha_next = quotient;
            mcnt_next  = MCNT_W'(FRAC_BITS);
        end
        else if (state_reg == ST_MUL)
        begin
            alpha_next = alpha_reg >> 1;
            mcnt_next  = mcnt_reg - 1'b1;
        end
    end

    // output register
    always_comb
    begin
        m_data_next = m_data_reg;
        if (out_load)
        begin
            for (int i = 0; i < COMP_N; i++)
                m_data_next[i*COMP_W +: COMP_W] = lane_res[i];
            m_data_next[COMP_N*COMP_W +: TIME_W]        = time_res;
            m_data_next[COMP_N*COMP_W + TIME_W +: NUM_W] = num_reg;
        end
        if (out_load)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    sci_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (np_abs[COMP_W-1:0]),
        .den      (den),
        .done     (div_done),
        .quotient (quotient)
    );

    for (genvar g = 0; g < COMP_N; g++)
    begin : g_comp_lane
        sci_lane #(
            .W (COMP_W)
        ) u_lane (
            .clk    (clk),
            .ctrl   (lane_ctrl),
            .a      ({prev_comp_reg[g][COMP_W-1], prev_comp_reg[g]}),
            .b      ({cur_comp[g][COMP_W-1], cur_comp[g]}),
            .result (lane_res[g])
        );
    end

    sci_lane #(
        .W (TIME_W)
    ) u_time_lane (
        .clk    (clk),
        .ctrl   (lane_ctrl),
        .a      ({1'b0, prev_time_reg}),
        .b      ({1'b0, cur_time}),
        .result (time_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            select_reg    <= SELECT_RESET;
            level_reg     <= '0;
            mode_reg      <= MODE_UP;
            have_prev_reg <= 1'b0;
            count_reg     <= '0;
            mcnt_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            select_reg    <= select_next;
            level_reg     <= level_next;
            mode_reg      <= mode_next;
            have_prev_reg <= have_prev_next;
            count_reg     <= count_next;
            mcnt_reg      <= mcnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < COMP_N; i++)
                prev_comp_reg[i] <= cur_comp[i];
            prev_time_reg <= cur_time;
            dp_reg        <= dp;
            dc_reg        <= dc;
        end
        num_reg    <= num_next;
        alpha_reg  <= alpha_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

FILE: sv/sci_checker.sv
`timescale 1ns / 1ps

module sci_checker
    import sci_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else
        $error("result changed while stalled");

    // the input side closes only after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(s_tvalid))
    else
        $error("s_tready dropped without an input transfer");

    // a new result comes with the input side opening again
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $rose(s_tready))
    else
        $error("result appeared while input side stayed closed");

endmodule

bind section_crossing_interpolator sci_checker u_checker (.*);

FILE: test/section_crossing_interpolator_tb.sv
`timescale 1ns / 1ps

module section_crossing_interpolator_tb;
    import sci_pkg::*;

    localparam int FRAC         = 24;
    localparam int CNT_W        = 16;
    localparam int DRAIN_CYCLES = 2 * FRAC + 8;

    // index past the register list, and the mode that accepts nothing
    localparam logic [CFG_ADDR_W-1:0] REG_NONE  = 2'd3;
    localparam logic [MODE_W-1:0]     MODE_NONE = 2'd3;

    localparam logic [COMP_W-1:0] COMP_MAX = 32'h7FFF_FFFF;
    localparam logic [COMP_W-1:0] COMP_MIN = 32'h8000_0000;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef struct packed {
        logic                             start;
        logic [TIME_W-1:0]                stamp;
        logic [COMP_N-1:0][COMP_W-1:0]    comp;
    } sample_t;

    typedef struct packed {
        logic [NUM_W-1:0]                 number;
        logic [TIME_W-1:0]                stamp;
        logic [COMP_N-1:0][COMP_W-1:0]    comp;
    } crossing_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // register copies and sample history of the predictor
    logic [SEL_W-1:0]                 sel_reg = SELECT_RESET;
    logic signed [COMP_W-1:0]         level_reg = '0;
    logic [MODE_W-1:0]                mode_reg = MODE_UP;
    logic [COMP_N-1:0][COMP_W-1:0]    prev_comp = '0;
    logic [TIME_W-1:0]                prev_stamp = '0;
    logic                             have_prev = 1'b0;
    logic [CNT_W-1:0]                 cross_count = '0;

    crossing_t crossing_q[$];
    int        mismatch_count = 0;
    int        items_sent = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        hold_left = 0;

    logic              walk_above = 1'b0;
    logic [TIME_W-1:0] walk_stamp = '0;

    string comp_name[COMP_N] = '{"cross_x", "cross_y", "cross_z",
                                 "cross_vx", "cross_vy", "cross_vz"};

    section_crossing_interpolator #(
        .FRAC_BITS   (FRAC),
        .COUNT_WIDTH (CNT_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // Work out the crossing caused by one sample and advance the history.
    function automatic bit predict_crossing(input sample_t smp, output crossing_t res);
        longint            lvl, dp, dc, np, nc, alpha, d;
        logic signed [127:0] dt, pt, a128;
        bit                up, down, hit;
        int                i;
        hit = 1'b0;
        res = '0;
        if (smp.start)
            cross_count = '0;
        if (!smp.start && have_prev && sel_reg < COMP_N)
        begin
            lvl  = longint'(level_reg);
            dp   = longint'($signed(prev_comp[sel_reg])) - lvl;
            dc   = longint'($signed(smp.comp[sel_reg])) - lvl;
            up   = dp < 0 && dc > 0;
            down = dp > 0 && dc < 0;
            case (mode_reg)
                MODE_UP:     hit = up;
                MODE_DOWN:   hit = down;
                MODE_EITHER: hit = up || down;
                default:     hit = 1'b0;
            endcase
            if (hit)
            begin
                np    = dp < 0 ? -dp : dp;
                nc    = dc < 0 ? -dc : dc;
                alpha = (np << FRAC) / (np + nc);
                for (i = 0; i < COMP_N; i++)
                begin
                    d = longint'($signed(smp.comp[i])) - longint'($signed(prev_comp[i]));
                    d = (d * alpha) >>> FRAC;
                    res.comp[i] = prev_comp[i] + d[COMP_W-1:0];
                end
                a128 = alpha;
                dt = $signed({88'd0, smp.stamp}) - $signed({88'd0, prev_stamp});
                pt = (dt * a128) >>> FRAC;
                res.stamp = prev_stamp + pt[TIME_W-1:0];
                if (cross_count != NUM_MAX)
                    cross_count = cross_count + 1'b1;
                res.number = cross_count;
            end
        end
        prev_comp  = smp.comp;
        prev_stamp = smp.stamp;
        have_prev  = 1'b1;
        return hit;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Offer one sample, hold it until the transfer, then predict.
    task automatic send_sample(input sample_t smp);
        crossing_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {smp.stamp, smp.comp};
        s_tuser  <= smp.start;
        do @(posedge clk); while (!s_tready);
        if (predict_crossing(smp, res))
            crossing_q.insert(crossing_q.size(), res);
        items_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (crossing_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        drain_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        case (addr)
            REG_SELECT: sel_reg   = data[SEL_W-1:0];
            REG_LEVEL:  level_reg = data;
            REG_MODE:   mode_reg  = data[MODE_W-1:0];
            default:    ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic sample_t uniform_sample(input logic [COMP_W-1:0] v,
                                               input logic [TIME_W-1:0] t, input logic start);
        sample_t smp;
        int      i;
        for (i = 0; i < COMP_N; i++)
            smp.comp[i] = v;
        smp.stamp = t;
        smp.start = start;
        return smp;
    endfunction

    function automatic logic [COMP_W-1:0] near_level(input bit above);
        longint off, v;
        off = longint'($urandom >> $urandom_range(0, 31)) + 1;
        v   = above ? longint'(level_reg) + off : longint'(level_reg) - off;
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[COMP_W-1:0];
    endfunction

    function automatic logic [COMP_W-1:0] random_comp();
        case ($urandom_range(0, 9))
            0:       return COMP_MIN;
            1:       return COMP_MAX;
            2:       return '0;
            default: return 32'($urandom);
        endcase
    endfunction

    // One step of a trajectory whose selected component swings around the level.
    function automatic sample_t walk_sample(input bit start);
        sample_t           smp;
        logic [TIME_W-1:0] incr;
        int                i;
        for (i = 0; i < COMP_N; i++)
            smp.comp[i] = random_comp();
        if (sel_reg < COMP_N)
        begin
            if ($urandom_range(19) == 0)
                smp.comp[sel_reg] = level_reg;
            else
            begin
                if ($urandom_range(9) < 7)
                    walk_above = !walk_above;
                smp.comp[sel_reg] = near_level(walk_above);
            end
        end
        incr = TIME_W'($urandom >> $urandom_range(0, 31));
        case ($urandom_range(0, 19))
            0:       walk_stamp = {8'($urandom), 32'($urandom)};
            1:       walk_stamp = walk_stamp - incr;
            default: walk_stamp = walk_stamp + incr;
        endcase
        smp.stamp = walk_stamp;
        smp.start = start;
        return smp;
    endfunction

    task automatic randomize_setting();
        logic [SEL_W-1:0]      sel;
        logic [MODE_W-1:0]     mode;
        logic [CFG_DATA_W-1:0] lvl;
        sel  = ($urandom_range(99) < 85) ? SEL_W'($urandom_range(0, COMP_N - 1))
                                         : SEL_W'($urandom_range(COMP_N, 7));
        mode = ($urandom_range(99) < 90) ? MODE_W'($urandom_range(0, 2)) : MODE_NONE;
        case ($urandom_range(0, 5))
            0:       lvl = '0;
            1:       lvl = COMP_MAX;
            2:       lvl = COMP_MIN;
            default: lvl = 32'($urandom);
        endcase
        write_reg(REG_SELECT, (32'($urandom) & ~32'h7) | 32'(sel));
        write_reg(REG_LEVEL, lvl);
        write_reg(REG_MODE, (32'($urandom) & ~32'h3) | 32'(mode));
        if ($urandom_range(3) == 0)
            write_reg(REG_NONE, 32'($urandom));
    endtask

    // Reset defaults: select y, level 0, upward only.
    task automatic test_first_sample_and_touch();
        send_sample(uniform_sample(-32'sd1, TIME_MAX, 1'b0));
        send_sample(uniform_sample(32'sd1, '0, 1'b0));
        send_sample(uniform_sample('0, 40'd5, 1'b0));
        send_sample(uniform_sample(32'sd1, 40'd9, 1'b0));
        send_sample(uniform_sample(COMP_MIN, 40'd1, 1'b0));
        send_sample(uniform_sample(COMP_MAX, TIME_MAX, 1'b0));
        // a sign change on a start sample must not count
        send_sample(uniform_sample(COMP_MIN, 40'd7, 1'b1));
        send_sample(uniform_sample(COMP_MAX, 40'd20, 1'b0));
    endtask

    task automatic test_directions();
        write_reg(REG_MODE, 32'(MODE_DOWN));
        send_sample(uniform_sample(-32'sd5, 40'd30, 1'b0));
        send_sample(uniform_sample(32'sd7, 40'd31, 1'b0));
        send_sample(uniform_sample(-32'sd3, 40'd45, 1'b0));
        write_reg(REG_MODE, 32'(MODE_EITHER));
        send_sample(uniform_sample(32'sd9, 40'd50, 1'b0));
        send_sample(uniform_sample(-32'sd9, 40'd60, 1'b0));
        write_reg(REG_MODE, 32'(MODE_NONE));
        send_sample(uniform_sample(32'sd4, 40'd70, 1'b0));
        send_sample(uniform_sample(-32'sd4, 40'd80, 1'b0));
    endtask

    task automatic test_selectors();
        logic [COMP_W-1:0] lvl;
        int                c;
        lvl = 32'h0123_4567;
        write_reg(REG_MODE, 32'(MODE_EITHER));
        write_reg(REG_LEVEL, lvl);
        write_reg(REG_NONE, 32'($urandom));
        for (c = 0; c < COMP_N + 2; c++)
        begin
            write_reg(REG_SELECT, (32'($urandom) & ~32'h7) | 32'(c));
            send_sample(uniform_sample(c[0] ? lvl - 1 : lvl + 1, 40'(100 + c), 1'b0));
        end
        write_reg(REG_SELECT, 32'(SELECT_RESET));
        write_reg(REG_LEVEL, COMP_MAX);
        send_sample(uniform_sample(COMP_MAX, 40'd200, 1'b0));
        send_sample(uniform_sample(COMP_MIN, 40'd201, 1'b0));
        write_reg(REG_LEVEL, COMP_MIN);
        send_sample(uniform_sample(COMP_MIN, 40'd202, 1'b0));
        send_sample(uniform_sample(COMP_MAX, 40'd203, 1'b0));
    endtask

    // Stall the output long enough that the block backs up into its input.
    task automatic test_backpressure();
        int k;
        int saved_send, saved_recv;
        saved_send = send_idle_pct;
        saved_recv = recv_idle_pct;
        send_idle_pct = 0;
        write_reg(REG_SELECT, 32'(SELECT_RESET));
        write_reg(REG_LEVEL, '0);
        write_reg(REG_MODE, 32'(MODE_EITHER));
        send_sample(walk_sample(1'b1));
        hold_left = 400;
        for (k = 0; k < 24; k++)
            send_sample(walk_sample(1'b0));
        // pause the sender until every crossing has drained
        drain_results();
        send_idle_pct = saved_send;
        recv_idle_pct = saved_recv;
    endtask

    task automatic test_random(input int total);
        int      ph, k, j, len, target;
        sample_t smp;
        int      send_pct[3] = '{23, 49, 0};
        int      recv_pct[3] = '{49, 23, 0};
        for (ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = send_pct[ph];
            recv_idle_pct = recv_pct[ph];
            for (k = 0; k < 4; k++)
            begin
                randomize_setting();
                target = items_sent + total / 12;
                while (items_sent < target)
                begin
                    if ($urandom_range(9) == 0)
                    begin
                        smp.comp  = {6{32'($urandom)}};
                        for (j = 0; j < COMP_N; j++)
                            smp.comp[j] = 32'($urandom);
                        smp.stamp = {8'($urandom), 32'($urandom)};
                        smp.start = 1'($urandom);
                        send_sample(smp);
                    end
                    else
                    begin
                        len = $urandom_range(1, 40);
                        for (j = 0; j < len; j++)
                            send_sample(walk_sample(j == 0 && $urandom_range(9) != 0));
                    end
                end
            end
        end
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin : result_checker
        crossing_t got, want;
        int        i;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (crossing_q.size() == 0)
                    report_mismatch($sformatf("result with no crossing pending: %0h", got));
                else
                begin
                    want = crossing_q.pop_front();
                    for (i = 0; i < COMP_N; i++)
                        if (got.comp[i] !== want.comp[i])
                            report_mismatch($sformatf("%s got %0h expected %0h",
                                comp_name[i], got.comp[i], want.comp[i]));
                    if (got.stamp !== want.stamp)
                        report_mismatch($sformatf("cross_time got %0h expected %0h",
                            got.stamp, want.stamp));
                    if (got.number !== want.number)
                        report_mismatch($sformatf("crossing_number got %0d expected %0d",
                            got.number, want.number));
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 23;
        recv_idle_pct = 49;
        test_first_sample_and_touch();
        test_directions();
        test_selectors();
        test_backpressure();
        test_random(1800);
        drain_results();
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: sim.f
sv/sci_pkg.sv
sv/sci_divider.sv
sv/sci_lane.sv
sv/section_crossing_interpolator.sv
sv/sci_checker.sv
test/section_crossing_interpolator_tb.sv
